### rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bum_pkg.sv
// shared widths, register indexes and types of the battery undervoltage monitor
package bum_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int TIME_W   = 32;
   localparam int MV_W     = 16;
   localparam int SCALE_W  = 16;
   localparam int THR_W    = 16;
   localparam int HOLD_W   = 32;

   // scale is unsigned q8
   localparam int Q_SHIFT = 8;
   localparam int PROD_W  = SAMPLE_W + SCALE_W;

   // stream packing
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MV_PER_COUNT_Q8    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_THRESHOLD_MV = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME_MS       = 2'd2;

   localparam logic [SCALE_W-1:0] MV_PER_COUNT_Q8_RESET    = 16'd1180;
   localparam logic [THR_W-1:0]   FAULT_THRESHOLD_MV_RESET = 16'd10000;
   localparam logic [HOLD_W-1:0]  HOLD_TIME_MS_RESET       = 32'd1000;

   localparam logic [MV_W-1:0] MV_MAX = 16'hFFFF;

   // one block verdict handed to the hold timer
   typedef struct packed {
      logic update;
      logic is_low;
   } hold_req_type;

endpackage

### rtl/bum_hold_timer.sv
// low-voltage period tracker that raises the fault after the hold time
`include "assert_macros.svh"

module bum_hold_timer (
   input  logic                        clock,
   input  logic                        reset,
   input  bum_pkg::hold_req_type       hold_req,
   input  logic [bum_pkg::TIME_W-1:0]  time_ms,
   input  logic [bum_pkg::HOLD_W-1:0]  hold_time_ms,
   output logic                        fault_out
);
   import bum_pkg::*;

   logic              low_active_ff, low_active_in;
   logic              fault_ff, fault_in;
   logic [TIME_W-1:0] low_since_ff, low_since_in;
   logic [TIME_W-1:0] since_eff;
   logic [TIME_W-1:0] elapsed;
   logic              held_long;

   // start of the low period, this block's time when it only now begins
   assign since_eff = low_active_ff ? low_since_ff : time_ms;
   assign elapsed   = time_ms - since_eff;
   assign held_long = (elapsed >= hold_time_ms);

   // next state of the tracker
   always_comb begin
      low_active_in = low_active_ff;
      low_since_in  = low_since_ff;
      fault_in      = fault_ff;
      if (hold_req.update) begin
         if (hold_req.is_low) begin
            low_active_in = 1'b1;
            low_since_in  = since_eff;
            fault_in      = fault_ff | held_long;
         end else begin
            low_active_in = 1'b0;
            low_since_in  = '0;
            fault_in      = 1'b0;
         end
      end
   end

   // fault as it stands after this block
   assign fault_out = fault_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_active_ff <= 1'b0;
         fault_ff      <= 1'b0;
      end else begin
         low_active_ff <= low_active_in;
         fault_ff      <= fault_in;
      end
   end

   // timestamp of the low period start
   always_ff @(posedge clock) begin
      low_since_ff <= low_since_in;
   end

   `ASSERT_IMPLIES(a_fault_needs_low, clock, reset, fault_ff, low_active_ff, "fault without low period")
   `ASSERT_NEXT(a_high_clears, clock, reset, hold_req.update && !hold_req.is_low, !low_active_ff && !fault_ff, "high block did not clear")
   `ASSERT_NEXT(a_low_starts, clock, reset, hold_req.update && hold_req.is_low, low_active_ff, "low block did not start period")

endmodule

### rtl/battery_undervoltage_monitor.sv
// Battery undervoltage monitor: averages AVG_SAMPLES converter samples per block and, on the
// last sample of each block, returns the truncated average, the battery voltage in mV
// ((average * mv_per_count_q8) >> 8, saturated at 65535), the low-voltage fault and the
// timestamp of that sample. One sample is taken every cycle while req_tready is high;
// samples that do not close a block give no response. A response passes through a pipeline
// of four registers (block sum, average by reciprocal multiply, scale multiply, threshold and
// hold-time check); a stage moves on only when the next is empty or moving, so a waiting
// response can stall the request side too. The user must write configuration through the csr
// port only while no block result is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module battery_undervoltage_monitor #(
   parameter int AVG_SAMPLES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bum_pkg::REQ_DATA_W-1:0]   req_tdata,  // sample[11:0], time_ms[43:12]
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bum_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // average_raw[11:0], battery_mv[27:12],
                                                        // low_fault[28], read_time_ms[60:29]
   // configuration writes
   input  logic                             csr_we,
   input  logic [bum_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bum_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bum_pkg::*;

   localparam int LOG_N   = $clog2(AVG_SAMPLES);
   localparam int SUM_W   = SAMPLE_W + LOG_N;
   localparam int CNT_W   = (LOG_N > 0) ? LOG_N : 1;
   localparam int RECIP_W = SUM_W + 1;
   localparam int DIV_W   = SUM_W + RECIP_W;
   localparam int DIV_SH  = SUM_W + LOG_N;
   // ceil(2^(SUM_W+LOG_N) / AVG_SAMPLES): exact quotient for every block sum
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SH) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);

   // configuration registers
   logic [SCALE_W-1:0] mv_per_count_q8_ff;
   logic [THR_W-1:0]   fault_threshold_mv_ff;
   logic [HOLD_W-1:0]  hold_time_ms_ff;

   // request fields
   logic [SAMPLE_W-1:0] req_sample;
   logic [TIME_W-1:0]   req_time;
   logic                req_fire;
   logic                block_last;

   // accumulator
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] sum_next;

   // pipeline registers
   logic                s1_valid_ff;
   logic [SUM_W-1:0]    s1_sum_ff;
   logic [TIME_W-1:0]   s1_time_ff;
   logic                s2_valid_ff;
   logic [SAMPLE_W-1:0] s2_avg_ff;
   logic [TIME_W-1:0]   s2_time_ff;
   logic                s3_valid_ff;
   logic [SAMPLE_W-1:0] s3_avg_ff;
   logic [PROD_W-1:0]   s3_prod_ff;
   logic [TIME_W-1:0]   s3_time_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_avg_ff;
   logic [MV_W-1:0]     rsp_mv_ff;
   logic                rsp_fault_ff;
   logic [TIME_W-1:0]   rsp_time_ff;

   // stage flow
   logic out_free;
   logic s3_free;
   logic s2_free;
   logic s1_free;

   // datapath
   logic [DIV_W-1:0]    div_prod;
   logic [SAMPLE_W-1:0] avg_q;
   logic [PROD_W-1:0]   scale_prod;
   logic [MV_W-1:0]     mv_sat;
   logic                is_low;
   hold_req_type        hold_req;
   logic                fault_now;

   // configuration writes, out-of-range index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_per_count_q8_ff    <= MV_PER_COUNT_Q8_RESET;
         fault_threshold_mv_ff <= FAULT_THRESHOLD_MV_RESET;
         hold_time_ms_ff       <= HOLD_TIME_MS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MV_PER_COUNT_Q8:    mv_per_count_q8_ff    <= csr_wdata[SCALE_W-1:0];
            CSR_FAULT_THRESHOLD_MV: fault_threshold_mv_ff <= csr_wdata[THR_W-1:0];
            CSR_HOLD_TIME_MS:       hold_time_ms_ff       <= csr_wdata[HOLD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // each stage moves on when the one after it is empty or moving
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_tready = s1_free;
   assign req_fire   = req_tvalid && req_tready;
   assign req_sample = req_tdata[SAMPLE_W-1:0];
   assign req_time   = req_tdata[SAMPLE_W +: TIME_W];

   // block accumulation
   assign sum_next   = sum_ff + SUM_W'(req_sample);
   assign block_last = (cnt_ff == LAST_CNT);

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (req_fire) begin
         if (block_last) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   // divide by the block length through the reciprocal
   assign div_prod = {{RECIP_W{1'b0}}, s1_sum_ff} * {{SUM_W{1'b0}}, RECIP};
   assign avg_q    = div_prod[DIV_SH +: SAMPLE_W];

   // scale to millivolts with saturation
   assign scale_prod = {{SCALE_W{1'b0}}, s2_avg_ff} * {{SAMPLE_W{1'b0}}, mv_per_count_q8_ff};
   assign mv_sat     = (|s3_prod_ff[PROD_W-1:Q_SHIFT+MV_W]) ? MV_MAX
                                                            : s3_prod_ff[Q_SHIFT +: MV_W];
   assign is_low     = (mv_sat <= fault_threshold_mv_ff);

   // low-voltage hold tracking
   assign hold_req.update = s3_valid_ff && out_free;
   assign hold_req.is_low = is_low;

   bum_hold_timer u_hold_timer (
      .clock        (clock),
      .reset        (reset),
      .hold_req     (hold_req),
      .time_ms      (s3_time_ff),
      .hold_time_ms (hold_time_ms_ff),
      .fault_out    (fault_now)
   );

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (s1_valid_ff && !s2_free) || (req_fire && block_last);
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_fire && block_last) begin
         s1_sum_ff  <= sum_next;
         s1_time_ff <= req_time;
      end
      if (s2_free) begin
         s2_avg_ff  <= avg_q;
         s2_time_ff <= s1_time_ff;
      end
      if (s3_free) begin
         s3_avg_ff  <= s2_avg_ff;
         s3_prod_ff <= scale_prod;
         s3_time_ff <= s2_time_ff;
      end
      if (out_free) begin
         rsp_avg_ff   <= s3_avg_ff;
         rsp_mv_ff    <= mv_sat;
         rsp_fault_ff <= fault_now;
         rsp_time_ff  <= s3_time_ff;
      end
   end

   // response packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_time_ff, rsp_fault_ff, rsp_mv_ff, rsp_avg_ff};

   `ASSERT_NEXT(a_block_close, clock, reset, req_fire && block_last, s1_valid_ff, "closing request lost")
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, cnt_ff <= LAST_CNT, "block count out of range")
   `ASSERT_IMPLIES(a_zero_avg_mv, clock, reset, rsp_valid_ff && rsp_avg_ff == '0, rsp_mv_ff == '0, "zero average gave nonzero voltage")

endmodule
